>>> sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Each macro takes a label, the clock, the active-low reset, an antecedent,
// a consequent and a message for the error report.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/gte_pkg.sv
`timescale 1ns / 1ps
package gte_pkg;

  localparam int VTX_W        = 6;
  localparam int MAX_VERTICES = 64;
  localparam int MAX_DEGREE   = 8;
  localparam int SLOT_W       = $clog2(MAX_DEGREE);
  localparam int DEG_W        = $clog2(MAX_DEGREE + 1);
  localparam int NV_W         = 7;
  localparam int CNT_W        = VTX_W + 1;
  localparam int NBR_AW       = VTX_W + SLOT_W;
  localparam int SCR_W        = VTX_W + DEG_W;

  localparam logic [NV_W-1:0] NV_RESET = NV_W'(MAX_VERTICES);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_BFS    = 2'd1,
    OP_DFS    = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_VISIT  = 2'd0,
    ST_EDGE   = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [VTX_W-1:0] first_vertex;
    logic [VTX_W-1:0] second_vertex;
  } in_t;

  typedef struct packed {
    logic [VTX_W-1:0] visited_vertex;
    logic [1:0]       status;
    logic             last;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_EDGE_RD,
    S_EDGE_CHK,
    S_EDGE_WU,
    S_EDGE_WV,
    S_EDGE_DONE,
    S_ERR,
    S_BFS_INIT,
    S_BFS_POP,
    S_BFS_CUR,
    S_BFS_DRD,
    S_BFS_DEG,
    S_BFS_NRD,
    S_BFS_NCHK,
    S_DFS_INIT,
    S_DFS_DRD,
    S_DFS_DEG,
    S_DFS_NRD,
    S_DFS_NCHK,
    S_DFS_POP,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic load_in;
    logic clr_visit;
    logic deg_rd_edge;
    logic edge_wr_u;
    logic edge_wr_v;
    logic res_edge;
    logic res_err;
    logic start_trav;
    logic fifo_pop;
    logic cur_load_fifo;
    logic deg_rd;
    logic deg_load;
    logic nbr_rd;
    logic bfs_take;
    logic dfs_take;
    logic stack_pop;
    logic cur_load_stack;
    logic visit_start;
    logic visit_cur;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       edge_ok;
    logic       start_ok;
    logic       fits;
    logic       idx_eq_deg;
    logic       fifo_empty;
    logic       stack_empty;
    logic       nb_new;
    logic       out_free;
    logic       emit_ok;
  } stat_t;

endpackage

>>> sv/graph_traversal_engine.sv
`timescale 1ns / 1ps
// Graph traversal engine. Keeps an undirected graph of up to 64 vertices as
// adjacency lists of at most eight entries each, and walks it breadth-first
// or depth-first from a start vertex. Each input word is an add-edge request
// or a traversal request; an add-edge gives one result word (added or
// rejected), a traversal gives one word per visited vertex in visit order,
// with last set on the final one. A rejected request (vertex out of range,
// list full or unused operation code) gives a single rejected word. The
// num_vertices register may only be written while the block is idle.
// The block takes one request at a time and stalls its input while working.
// An add-edge reads both degree counts, checks that the edge fits, writes
// the two list entries and then gives its word; a request rejected at decode
// goes straight to its rejected word. The next request can be taken in the
// cycle after the final word is loaded. A traversal reads each adjacency
// entry through the single read port of the neighbour table and its
// registered read data, and a stalled output holds it up. Finished words sit
// in an output register, so a new request is taken while the last word still
// waits.
module graph_traversal_engine (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  gte_pkg::in_t             in_word_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output gte_pkg::out_t            out_word_o,
  input  logic                     cfg_we_i,
  input  logic [gte_pkg::NV_W-1:0] cfg_wdata_i
);

  gte_pkg::cmd_t  cmd;
  gte_pkg::stat_t stat;

  // The controller sequences each request; the datapath holds the graph,
  // the scratch queue or stack, the visited marks and the output register.
  gte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gte_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

>>> sv/gte_ctrl.sv
`timescale 1ns / 1ps
module gte_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  gte_pkg::stat_t stat_i,
  output gte_pkg::cmd_t  cmd_o
);

  gte_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gte_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gte_pkg::S_IDLE: begin
        if (in_valid_i) state_d = gte_pkg::S_DECODE;
      end
      gte_pkg::S_DECODE: begin
        unique case (stat_i.op)
          gte_pkg::OP_ADD: state_d = stat_i.edge_ok ? gte_pkg::S_EDGE_RD : gte_pkg::S_ERR;
          gte_pkg::OP_BFS: state_d = stat_i.start_ok ? gte_pkg::S_BFS_INIT : gte_pkg::S_ERR;
          gte_pkg::OP_DFS: state_d = stat_i.start_ok ? gte_pkg::S_DFS_INIT : gte_pkg::S_ERR;
          default:         state_d = gte_pkg::S_ERR;
        endcase
      end
      gte_pkg::S_EDGE_RD:  state_d = gte_pkg::S_EDGE_CHK;
      gte_pkg::S_EDGE_CHK: state_d = stat_i.fits ? gte_pkg::S_EDGE_WU : gte_pkg::S_ERR;
      gte_pkg::S_EDGE_WU:  state_d = gte_pkg::S_EDGE_WV;
      gte_pkg::S_EDGE_WV:  state_d = gte_pkg::S_EDGE_DONE;
      gte_pkg::S_EDGE_DONE, gte_pkg::S_ERR, gte_pkg::S_FINISH: begin
        if (stat_i.out_free) state_d = gte_pkg::S_IDLE;
      end
      gte_pkg::S_BFS_INIT: state_d = gte_pkg::S_BFS_POP;
      gte_pkg::S_BFS_POP:  state_d = stat_i.fifo_empty ? gte_pkg::S_FINISH : gte_pkg::S_BFS_CUR;
      gte_pkg::S_BFS_CUR:  state_d = gte_pkg::S_BFS_DRD;
      gte_pkg::S_BFS_DRD:  state_d = gte_pkg::S_BFS_DEG;
      gte_pkg::S_BFS_DEG: begin
        if (stat_i.emit_ok) state_d = gte_pkg::S_BFS_NRD;
      end
      gte_pkg::S_BFS_NRD:  state_d = stat_i.idx_eq_deg ? gte_pkg::S_BFS_POP : gte_pkg::S_BFS_NCHK;
      gte_pkg::S_BFS_NCHK: state_d = gte_pkg::S_BFS_NRD;
      gte_pkg::S_DFS_INIT: begin
        if (stat_i.emit_ok) state_d = gte_pkg::S_DFS_DRD;
      end
      gte_pkg::S_DFS_DRD:  state_d = gte_pkg::S_DFS_DEG;
      gte_pkg::S_DFS_DEG:  state_d = gte_pkg::S_DFS_NRD;
      gte_pkg::S_DFS_NRD: begin
        if (!stat_i.idx_eq_deg) state_d = gte_pkg::S_DFS_NCHK;
        else if (stat_i.stack_empty) state_d = gte_pkg::S_FINISH;
        else state_d = gte_pkg::S_DFS_POP;
      end
      gte_pkg::S_DFS_NCHK: begin
        if (!stat_i.nb_new) state_d = gte_pkg::S_DFS_NRD;
        else if (stat_i.emit_ok) state_d = gte_pkg::S_DFS_DRD;
      end
      gte_pkg::S_DFS_POP:  state_d = gte_pkg::S_DFS_DRD;
      default:             state_d = gte_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      gte_pkg::S_IDLE:     cmd_o.load_in = in_valid_i;
      gte_pkg::S_DECODE:   cmd_o.clr_visit = 1'b1;
      gte_pkg::S_EDGE_RD:  cmd_o.deg_rd_edge = 1'b1;
      gte_pkg::S_EDGE_WU:  cmd_o.edge_wr_u = 1'b1;
      gte_pkg::S_EDGE_WV:  cmd_o.edge_wr_v = 1'b1;
      gte_pkg::S_EDGE_DONE: cmd_o.res_edge = stat_i.out_free;
      gte_pkg::S_ERR:      cmd_o.res_err = stat_i.out_free;
      gte_pkg::S_FINISH:   cmd_o.finish = stat_i.out_free;
      gte_pkg::S_BFS_INIT: cmd_o.start_trav = 1'b1;
      gte_pkg::S_BFS_POP:  cmd_o.fifo_pop = !stat_i.fifo_empty;
      gte_pkg::S_BFS_CUR:  cmd_o.cur_load_fifo = 1'b1;
      gte_pkg::S_BFS_DRD, gte_pkg::S_DFS_DRD: cmd_o.deg_rd = 1'b1;
      gte_pkg::S_BFS_DEG: begin
        cmd_o.deg_load  = stat_i.emit_ok;
        cmd_o.visit_cur = stat_i.emit_ok;
      end
      gte_pkg::S_BFS_NRD:  cmd_o.nbr_rd = !stat_i.idx_eq_deg;
      gte_pkg::S_BFS_NCHK: cmd_o.bfs_take = 1'b1;
      gte_pkg::S_DFS_INIT: begin
        cmd_o.start_trav  = stat_i.emit_ok;
        cmd_o.visit_start = stat_i.emit_ok;
      end
      gte_pkg::S_DFS_DEG:  cmd_o.deg_load = 1'b1;
      gte_pkg::S_DFS_NRD: begin
        cmd_o.nbr_rd    = !stat_i.idx_eq_deg;
        cmd_o.stack_pop = stat_i.idx_eq_deg && !stat_i.stack_empty;
      end
      gte_pkg::S_DFS_NCHK: cmd_o.dfs_take = stat_i.nb_new && stat_i.emit_ok;
      gte_pkg::S_DFS_POP:  cmd_o.cur_load_stack = 1'b1;
      default:             cmd_o = '0;
    endcase
  end

  assign in_stall_o = (state_q != gte_pkg::S_IDLE);

endmodule

>>> sv/gte_dp.sv
`timescale 1ns / 1ps
module gte_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  gte_pkg::in_t             in_word_i,
  input  logic                     cfg_we_i,
  input  logic [gte_pkg::NV_W-1:0] cfg_wdata_i,
  input  gte_pkg::cmd_t            cmd_i,
  output gte_pkg::stat_t           stat_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output gte_pkg::out_t            out_word_o
);

  gte_pkg::in_t in_q;
  logic [gte_pkg::NV_W-1:0]  nv_q, nv_eff;
  logic [gte_pkg::VTX_W-1:0] cur_v_q, pend_q;
  logic [gte_pkg::DEG_W-1:0] idx_q, deg_q;
  logic [gte_pkg::CNT_W-1:0] head_q, tail_q, top_q;
  logic [gte_pkg::MAX_VERTICES-1:0] visited_q, deg_vld_q;
  logic pend_vld_q, out_vld_q;
  gte_pkg::out_t out_q, out_d;
  logic out_load;

  logic [gte_pkg::VTX_W-1:0] nbr_mem [2**gte_pkg::NBR_AW];
  logic [gte_pkg::VTX_W-1:0] nbr_rdata_q;
  logic [gte_pkg::DEG_W-1:0] deg_mem [gte_pkg::MAX_VERTICES];
  logic [gte_pkg::DEG_W-1:0] deg_a_q, deg_b_q;
  logic [gte_pkg::SCR_W-1:0] scr_mem [gte_pkg::MAX_VERTICES];
  logic [gte_pkg::SCR_W-1:0] scr_rdata_q;

  logic [gte_pkg::VTX_W-1:0] u, v, nb, deg_addr_a, emit_v;
  logic [gte_pkg::DEG_W:0]   need, du_sum, dv_sum;
  logic [gte_pkg::DEG_W-1:0] dv_eff;
  logic self_loop, nb_new, out_free, emit_ok, emit;

  logic                      nbr_we, deg_we, scr_we;
  logic [gte_pkg::NBR_AW-1:0] nbr_waddr;
  logic [gte_pkg::VTX_W-1:0]  nbr_wdata, deg_waddr;
  logic [gte_pkg::DEG_W-1:0]  deg_wdata;
  logic [gte_pkg::VTX_W-1:0]  scr_waddr, scr_raddr;
  logic [gte_pkg::SCR_W-1:0]  scr_wdata;
  logic [gte_pkg::CNT_W-1:0]  top_dec;

  assign u  = in_q.first_vertex;
  assign v  = in_q.second_vertex;
  assign nb = nbr_rdata_q;

  // A zero register acts as one vertex, anything above the table size as the table size.
  always_comb begin
    if (nv_q == '0) nv_eff = gte_pkg::NV_W'(1);
    else if (nv_q > gte_pkg::NV_RESET) nv_eff = gte_pkg::NV_RESET;
    else nv_eff = nv_q;
  end

  assign self_loop = (u == v);
  assign need      = self_loop ? (gte_pkg::DEG_W+1)'(2) : (gte_pkg::DEG_W+1)'(1);
  assign du_sum    = {1'b0, deg_a_q} + need;
  assign dv_sum    = {1'b0, deg_b_q} + need;
  // On a self-loop the second append lands one slot after the first.
  assign dv_eff    = self_loop ? deg_a_q + gte_pkg::DEG_W'(1) : deg_b_q;
  assign nb_new    = ({1'b0, nb} < nv_eff) && !visited_q[nb];
  assign out_free  = !out_vld_q || !out_stall_i;
  assign emit_ok   = !pend_vld_q || out_free;
  assign top_dec   = top_q - gte_pkg::CNT_W'(1);

  always_comb begin
    stat_o.op          = in_q.op;
    stat_o.edge_ok     = ({1'b0, u} < nv_eff) && ({1'b0, v} < nv_eff);
    stat_o.start_ok    = ({1'b0, u} < nv_eff);
    stat_o.fits        = (du_sum <= (gte_pkg::DEG_W+1)'(gte_pkg::MAX_DEGREE)) &&
                         (dv_sum <= (gte_pkg::DEG_W+1)'(gte_pkg::MAX_DEGREE));
    stat_o.idx_eq_deg  = (idx_q == deg_q);
    stat_o.fifo_empty  = (head_q == tail_q);
    stat_o.stack_empty = (top_q == '0);
    stat_o.nb_new      = nb_new;
    stat_o.out_free    = out_free;
    stat_o.emit_ok     = emit_ok;
  end

  // Configuration and the latched input word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= gte_pkg::NV_RESET;
    end else if (cfg_we_i) begin
      nv_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) in_q <= in_word_i;
  end

  // Neighbour table: one write port, one registered read port.
  always_comb begin
    nbr_we    = cmd_i.edge_wr_u || cmd_i.edge_wr_v;
    nbr_waddr = cmd_i.edge_wr_u ? {u, deg_a_q[gte_pkg::SLOT_W-1:0]}
                                : {v, dv_eff[gte_pkg::SLOT_W-1:0]};
    nbr_wdata = cmd_i.edge_wr_u ? v : u;
  end

  always_ff @(posedge clk_i) begin
    if (nbr_we) nbr_mem[nbr_waddr] <= nbr_wdata;
    if (cmd_i.nbr_rd) nbr_rdata_q <= nbr_mem[{cur_v_q, idx_q[gte_pkg::SLOT_W-1:0]}];
  end

  // Degree counts: two registered read ports; an entry never written reads as zero.
  assign deg_addr_a = cmd_i.deg_rd_edge ? u : cur_v_q;

  always_comb begin
    deg_we    = cmd_i.edge_wr_u || cmd_i.edge_wr_v;
    deg_waddr = cmd_i.edge_wr_u ? u : v;
    deg_wdata = cmd_i.edge_wr_u ? deg_a_q + gte_pkg::DEG_W'(1)
                                : dv_eff + gte_pkg::DEG_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_vld_q <= '0;
    end else if (deg_we) begin
      deg_vld_q[deg_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
    if (cmd_i.deg_rd_edge || cmd_i.deg_rd) begin
      deg_a_q <= deg_vld_q[deg_addr_a] ? deg_mem[deg_addr_a] : '0;
    end
    if (cmd_i.deg_rd_edge) begin
      deg_b_q <= deg_vld_q[v] ? deg_mem[v] : '0;
    end
  end

  // Scratch memory: queue for breadth-first, stack of (vertex, slot) for depth-first.
  always_comb begin
    scr_we    = cmd_i.start_trav || (cmd_i.bfs_take && nb_new) || cmd_i.dfs_take;
    scr_waddr = '0;
    scr_wdata = {{gte_pkg::DEG_W{1'b0}}, u};
    if (cmd_i.bfs_take) begin
      scr_waddr = tail_q[gte_pkg::VTX_W-1:0];
      scr_wdata = {{gte_pkg::DEG_W{1'b0}}, nb};
    end else if (cmd_i.dfs_take) begin
      scr_waddr = top_q[gte_pkg::VTX_W-1:0];
      scr_wdata = {idx_q, cur_v_q};
    end
    scr_raddr = cmd_i.stack_pop ? top_dec[gte_pkg::VTX_W-1:0] : head_q[gte_pkg::VTX_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (scr_we) scr_mem[scr_waddr] <= scr_wdata;
    if (cmd_i.fifo_pop || cmd_i.stack_pop) scr_rdata_q <= scr_mem[scr_raddr];
  end

  // Walk registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_trav) begin
      cur_v_q <= u;
      idx_q   <= '0;
      head_q  <= '0;
      tail_q  <= gte_pkg::CNT_W'(1);
      top_q   <= '0;
    end else begin
      if (cmd_i.cur_load_fifo) begin
        cur_v_q <= scr_rdata_q[gte_pkg::VTX_W-1:0];
        idx_q   <= '0;
      end
      if (cmd_i.cur_load_stack) begin
        cur_v_q <= scr_rdata_q[gte_pkg::VTX_W-1:0];
        idx_q   <= scr_rdata_q[gte_pkg::SCR_W-1:gte_pkg::VTX_W];
      end
      if (cmd_i.nbr_rd) idx_q <= idx_q + gte_pkg::DEG_W'(1);
      if (cmd_i.fifo_pop) head_q <= head_q + gte_pkg::CNT_W'(1);
      if (cmd_i.bfs_take && nb_new) tail_q <= tail_q + gte_pkg::CNT_W'(1);
      if (cmd_i.stack_pop) top_q <= top_dec;
      if (cmd_i.dfs_take) begin
        top_q   <= top_q + gte_pkg::CNT_W'(1);
        cur_v_q <= nb;
        idx_q   <= '0;
      end
    end
    if (cmd_i.deg_load) deg_q <= deg_a_q;
  end

  // Visited marks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q <= '0;
    end else if (cmd_i.clr_visit) begin
      visited_q <= '0;
    end else if (cmd_i.start_trav) begin
      visited_q[u] <= 1'b1;
    end else if ((cmd_i.bfs_take && nb_new) || cmd_i.dfs_take) begin
      visited_q[nb] <= 1'b1;
    end
  end

  // The newest visit waits in pend_q until the next one shows it was not the last.
  assign emit   = cmd_i.visit_start || cmd_i.visit_cur || cmd_i.dfs_take;
  assign emit_v = cmd_i.visit_start ? u : (cmd_i.visit_cur ? cur_v_q : nb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
    end else if (emit) begin
      pend_vld_q <= 1'b1;
    end else if (cmd_i.finish) begin
      pend_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) pend_q <= emit_v;
  end

  always_comb begin
    out_load = 1'b1;
    out_d    = '0;
    priority if (cmd_i.res_edge) begin
      out_d.status = gte_pkg::ST_EDGE;
      out_d.last   = 1'b1;
    end else if (cmd_i.res_err) begin
      out_d.status = gte_pkg::ST_REJECT;
      out_d.last   = 1'b1;
    end else if (cmd_i.finish) begin
      out_d.visited_vertex = pend_q;
      out_d.status         = gte_pkg::ST_VISIT;
      out_d.last           = 1'b1;
    end else if (emit && pend_vld_q) begin
      out_d.visited_vertex = pend_q;
      out_d.status         = gte_pkg::ST_VISIT;
    end else begin
      out_load = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_load || (out_vld_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

>>> sv/gte_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gte_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input gte_pkg::in_t  in_word_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input gte_pkg::out_t out_word_o
);

  // A stalled result word stays put.
  `GTE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o), "stalled result word changed")

  // A stalled request word stays put.
  `GTE_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_valid_i && in_stall_o, in_valid_i && $stable(in_word_i), "stalled request word changed")

  // After taking a request the block is busy in the next cycle.
  `GTE_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "request taken without going busy")

  // Edge and rejected results stand alone and carry vertex zero.
  `GTE_ASSERT_IMP(a_single_result, clk_i, rst_ni, out_valid_o && (out_word_o.status != gte_pkg::ST_VISIT), out_word_o.last && (out_word_o.visited_vertex == '0), "edge or reject result malformed")

endmodule

bind graph_traversal_engine gte_checker u_gte_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
